// ===== sv/afv_pkg.sv =====
// Shared types, widths and helper functions for the box visibility test.
package afv_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int COORD_W = 16;
  localparam int EXT_W = 15;
  localparam int COEFF_W = 16;
  localparam int PLANE_W = 4 * COEFF_W;
  localparam int CFG_IDX_W = 3;
  localparam int CEN_PROD_W = 2 * COEFF_W;
  localparam int EXT_PROD_W = COEFF_W + EXT_W;
  localparam int SUM_W = 36;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR = 3'd5;

  typedef logic [PLANE_W-1:0] plane_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] a;
    logic signed [COEFF_W-1:0] b;
    logic signed [COEFF_W-1:0] c;
    logic signed [COEFF_W-1:0] d;
  } coeffs_t;

  typedef struct packed {
    logic signed [CEN_PROD_W-1:0] pa;
    logic signed [CEN_PROD_W-1:0] pb;
    logic signed [CEN_PROD_W-1:0] pc;
    logic [EXT_PROD_W-1:0] qa;
    logic [EXT_PROD_W-1:0] qb;
    logic [EXT_PROD_W-1:0] qc;
    logic signed [COEFF_W-1:0] d;
  } prod_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] cen;
    logic [SUM_W-1:0] ext;
  } psum_t;

  function automatic coeffs_t unpack_plane(input plane_t p);
    coeffs_t r;
    r.a = p[COEFF_W-1:0];
    r.b = p[2*COEFF_W-1:COEFF_W];
    r.c = p[3*COEFF_W-1:2*COEFF_W];
    r.d = p[4*COEFF_W-1:3*COEFF_W];
    return r;
  endfunction

  function automatic logic [COEFF_W-1:0] mag(input logic signed [COEFF_W-1:0] v);
    logic [COEFF_W-1:0] r;
    r = v[COEFF_W-1] ? (~v + COEFF_W'(1)) : v;
    return r;
  endfunction

endpackage

// ===== sv/afv_in_if.sv =====
// Input channel carrying one box per transaction.
interface afv_in_if
  import afv_pkg::*;
();
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic [EXT_W-1:0] half_extent_x;
  logic [EXT_W-1:0] half_extent_y;
  logic [EXT_W-1:0] half_extent_z;

  modport source (
    output valid, center_x, center_y, center_z,
    output half_extent_x, half_extent_y, half_extent_z,
    input ready
  );
  modport sink (
    input valid, center_x, center_y, center_z,
    input half_extent_x, half_extent_y, half_extent_z,
    output ready
  );
endinterface

// ===== sv/afv_out_if.sv =====
// Result channel carrying one visibility flag per transaction.
interface afv_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

// ===== sv/afv_cfg_if.sv =====
// Configuration write channel carrying a register index and its data.
interface afv_cfg_if
  import afv_pkg::*;
();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PLANE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/aabb_frustum_visibility_test.sv =====
// Top level of the box against frustum visibility test.
// The block tests one axis-aligned box per transaction against six planes
// held in registers 0 to 5 (left, right, bottom, top, near, far), each packing
// a, b, c and d as signed 16-bit values from the low bits up. A box is culled
// when some plane has all eight corners strictly below zero; a dot product of
// exactly zero counts as inside. Each plane is judged by its most positive
// corner, so every corner product is exact. A new box can be accepted in every
// cycle while the output is not stalled; the products, partial sums, plane
// signs and the output register are registered in that order. Stages with no
// valid item fill while the output waits, so the input stalls only when the
// whole pipeline is full. Plane registers must only be written while the
// pipeline is empty.
module aabb_frustum_visibility_test
  import afv_pkg::*;
(
  input logic clk,
  input logic rst_n,
  afv_in_if.sink in_ch,
  afv_out_if.source out_ch,
  afv_cfg_if.sink cfg_ch
);

  plane_t planes_r [PLANE_COUNT];

  logic s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, out_valid_nxt;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_fire, cfg_fire;

  prod_t prod_nxt [PLANE_COUNT];
  prod_t prod_r [PLANE_COUNT];
  psum_t psum_nxt [PLANE_COUNT];
  psum_t psum_r [PLANE_COUNT];
  logic [PLANE_COUNT-1:0] neg_nxt, neg_r;
  logic visible_r;
  logic ext_neg_any;

  assign rdy4 = !out_valid_r || out_ch.ready;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;

  assign in_ch.ready = rdy1;
  assign in_fire = in_ch.valid && rdy1;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire = cfg_ch.valid;

  assign out_ch.valid = out_valid_r;
  assign out_ch.visible = visible_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        planes_r[i] <= '0;
      end
    end else if (cfg_fire) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        if (cfg_ch.index == CFG_IDX_W'(i)) begin
          planes_r[i] <= cfg_ch.data;
        end
      end
    end
  end

  always_comb begin
    coeffs_t cf;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      cf = unpack_plane(planes_r[i]);
      prod_nxt[i].pa = cf.a * in_ch.center_x;
      prod_nxt[i].pb = cf.b * in_ch.center_y;
      prod_nxt[i].pc = cf.c * in_ch.center_z;
      prod_nxt[i].qa = mag(cf.a) * in_ch.half_extent_x;
      prod_nxt[i].qb = mag(cf.b) * in_ch.half_extent_y;
      prod_nxt[i].qc = mag(cf.c) * in_ch.half_extent_z;
      prod_nxt[i].d = cf.d;
    end
  end

  always_comb begin
    for (int i = 0; i < PLANE_COUNT; i++) begin
      psum_nxt[i].cen = SUM_W'(prod_r[i].pa) + SUM_W'(prod_r[i].pb)
                      + SUM_W'(prod_r[i].pc) + SUM_W'(prod_r[i].d);
      psum_nxt[i].ext = SUM_W'(prod_r[i].qa) + SUM_W'(prod_r[i].qb)
                      + SUM_W'(prod_r[i].qc);
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] total;
    ext_neg_any = 1'b0;
    for (int i = 0; i < PLANE_COUNT; i++) begin
      total = psum_r[i].cen + signed'(psum_r[i].ext);
      neg_nxt[i] = total[SUM_W-1];
      ext_neg_any = ext_neg_any | psum_r[i].ext[SUM_W-1];
    end
  end

  always_comb begin
    s1_v_nxt = rdy1 ? in_ch.valid : s1_v_r;
    s2_v_nxt = rdy2 ? s1_v_r : s2_v_r;
    s3_v_nxt = rdy3 ? s2_v_r : s3_v_r;
    out_valid_nxt = rdy4 ? s3_v_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prod_r <= prod_nxt;
    end
    if (rdy2 && s1_v_r) begin
      psum_r <= psum_nxt;
    end
    if (rdy3 && s2_v_r) begin
      neg_r <= neg_nxt;
    end
    if (rdy4 && s3_v_r) begin
      visible_r <= !(|neg_r);
    end
  end

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !s1_v_r && !s2_v_r && !s3_v_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_v_r)
    else $error("accepted transaction did not enter the first stage");

  a_ext_positive: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> !ext_neg_any)
    else $error("extent sum overflowed into its sign bit");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !rdy4) |=> s3_v_r && $stable(neg_r))
    else $error("stalled plane signs were lost or changed");

endmodule

// ===== bench/visibility_checker.sv =====
// Checker that predicts and compares the visibility flag of every box transaction.
`timescale 1ns / 1ps

module visibility_checker
  import afv_pkg::*;
(
  input logic clk,
  input logic rst_n,
  afv_in_if in_ch,
  afv_out_if out_ch,
  afv_cfg_if cfg_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [EXT_W-1:0] ex;
    logic [EXT_W-1:0] ey;
    logic [EXT_W-1:0] ez;
    logic visible;
  } box_verdict_t;

  plane_t plane_regs [PLANE_COUNT];
  box_verdict_t verdict_q [$];
  int unsigned fails;

  function automatic longint coeff_of(input plane_t p, input int slot);
    logic signed [COEFF_W-1:0] raw;
    raw = p[slot*COEFF_W +: COEFF_W];
    return longint'(raw);
  endfunction

  // A plane rejects the box only when all eight corners lie strictly behind it.
  function automatic logic box_visible(input box_verdict_t b);
    longint a, bc, c, d;
    longint lcx, lcy, lcz, lex, ley, lez;
    longint x, y, z;
    logic any_in;
    lcx = b.cx;
    lcy = b.cy;
    lcz = b.cz;
    lex = b.ex;
    ley = b.ey;
    lez = b.ez;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      a = coeff_of(plane_regs[p], 0);
      bc = coeff_of(plane_regs[p], 1);
      c = coeff_of(plane_regs[p], 2);
      d = coeff_of(plane_regs[p], 3);
      any_in = 1'b0;
      for (int k = 0; k < 8; k++) begin
        x = k[0] ? lcx + lex : lcx - lex;
        y = k[1] ? lcy + ley : lcy - ley;
        z = k[2] ? lcz + lez : lcz - lez;
        if (a * x + bc * y + c * z + d >= 0) begin
          any_in = 1'b1;
        end
      end
      if (!any_in) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    box_verdict_t entry;
    if (!rst_n) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        plane_regs[i] = '0;
      end
      verdict_q.delete();
      fails = 0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < PLANE_COUNT) begin
        plane_regs[cfg_ch.index] = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        entry.cx = in_ch.center_x;
        entry.cy = in_ch.center_y;
        entry.cz = in_ch.center_z;
        entry.ex = in_ch.half_extent_x;
        entry.ey = in_ch.half_extent_y;
        entry.ez = in_ch.half_extent_z;
        entry.visible = box_visible(entry);
        verdict_q.push_back(entry);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: result transaction with nothing outstanding, visible %0b",
                     $time, out_ch.visible);
          end
          fails++;
        end else begin
          entry = verdict_q.pop_front();
          if (out_ch.visible !== entry.visible) begin
            if (fails < 10) begin
              $display("%0t: box (%0d,%0d,%0d) half (%0d,%0d,%0d): visible expected %0b, got %0b",
                       $time, entry.cx, entry.cy, entry.cz, entry.ex, entry.ey, entry.ez,
                       entry.visible, out_ch.visible);
            end
            fails++;
          end
        end
      end
      pending <= verdict_q.size();
      fail_count <= fails;
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the bench: clock, reset, box and plane stimulus, and the final verdict.
`timescale 1ns / 1ps

module testbench;
  import afv_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [EXT_W-1:0] ex;
    logic [EXT_W-1:0] ey;
    logic [EXT_W-1:0] ez;
  } box_t;

  logic clk;
  logic rst_n;
  int unsigned fail_count;
  int unsigned pending;

  afv_in_if in_ch ();
  afv_out_if out_ch ();
  afv_cfg_if cfg_ch ();

  aabb_frustum_visibility_test u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  visibility_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch),
    .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic plane_t pack_plane(input int a, input int b, input int c, input int d);
    return {16'(d), 16'(c), 16'(b), 16'(a)};
  endfunction

  function automatic box_t mk_box(input int cx, input int cy, input int cz,
                                  input int ex, input int ey, input int ez);
    box_t b;
    b.cx = 16'(cx);
    b.cy = 16'(cy);
    b.cz = 16'(cz);
    b.ex = 15'(ex);
    b.ey = 15'(ey);
    b.ez = 15'(ez);
    return b;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return -1;
      2: return 0;
      default: return 32767;
    endcase
  endfunction

  function automatic int extreme_ext();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return 16384;
      default: return 32767;
    endcase
  endfunction

  function automatic box_t random_box();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return mk_box(int'($urandom_range(0, 8000)) - 4000, int'($urandom_range(0, 8000)) - 4000,
                    int'($urandom_range(0, 8000)) - 4000, $urandom_range(0, 600),
                    $urandom_range(0, 600), $urandom_range(0, 600));
    end else if (r < 85) begin
      return mk_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    return mk_box(extreme_coord(), extreme_coord(), extreme_coord(),
                  extreme_ext(), extreme_ext(), extreme_ext());
  endfunction

  function automatic plane_t random_plane();
    int r;
    int mag;
    int d;
    r = $urandom_range(0, 9);
    mag = $urandom_range(1, 64) * ($urandom_range(0, 1) ? 1 : -1);
    d = int'($urandom_range(0, 40000)) - 20000;
    case (r)
      0: return '0;
      1: return pack_plane(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
      2, 3, 4, 5: return {$urandom, $urandom};
      6: return pack_plane(mag, 0, 0, d);
      7: return pack_plane(0, mag, 0, d);
      default: return pack_plane(0, 0, mag, d);
    endcase
  endfunction

  // Axis-aligned view volume around the origin, each face at its own distance.
  function automatic plane_t cube_face(input int axis, input int dir);
    int s;
    int face_d;
    s = $urandom_range(1, 8) * dir;
    face_d = $urandom_range(200, 4000) * (dir * s);
    case (axis)
      0: return pack_plane(s, 0, 0, face_d);
      1: return pack_plane(0, s, 0, face_d);
      default: return pack_plane(0, 0, s, face_d);
    endcase
  endfunction

  function automatic int next_gap(input bit quiet);
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_box(input box_t b, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.center_x <= b.cx;
    in_ch.center_y <= b.cy;
    in_ch.center_z <= b.cz;
    in_ch.half_extent_x <= b.ex;
    in_ch.half_extent_y <= b.ey;
    in_ch.half_extent_z <= b.ez;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input plane_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_planes(input plane_t l, input plane_t r, input plane_t bo,
                             input plane_t t, input plane_t n, input plane_t f);
    write_reg(REG_PLANE_LEFT, l);
    write_reg(REG_PLANE_RIGHT, r);
    write_reg(REG_PLANE_BOTTOM, bo);
    write_reg(REG_PLANE_TOP, t);
    write_reg(REG_PLANE_NEAR, n);
    write_reg(REG_PLANE_FAR, f);
    write_reg(CFG_IDX_W'(PLANE_COUNT + $urandom_range(0, 1)), {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int out_run;
    int out_stall;
    int r;
    out_run = 0;
    out_stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_run == 0 && out_stall == 0) begin
        r = $urandom_range(0, 99);
        if (r < 50) out_run = $urandom_range(1, 8);
        else if (r < 60) out_run = $urandom_range(50, 200);
        else if (r < 95) out_stall = $urandom_range(1, 3);
        else out_stall = $urandom_range(10, 40);
      end
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall--;
      end else begin
        out_ch.ready <= 1'b1;
        out_run--;
      end
    end
  end

  initial begin
    plane_t p8000;
    plane_t p7fff;
    int kind;
    bit quiet;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.center_x <= '0;
    in_ch.center_y <= '0;
    in_ch.center_z <= '0;
    in_ch.half_extent_x <= '0;
    in_ch.half_extent_y <= '0;
    in_ch.half_extent_z <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Planes still at their reset value of zero never reject anything.
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767), 0);
    send_box(mk_box(32767, 32767, 32767, 0, 0, 0), 0);
    send_box(mk_box(0, 0, 0, 0, 0, 0), 1);
    drain();

    load_planes(pack_plane(1, 0, 0, 1000), pack_plane(-1, 0, 0, 1000),
                pack_plane(0, 1, 0, 1000), pack_plane(0, -1, 0, 1000),
                pack_plane(0, 0, 1, 1000), pack_plane(0, 0, -1, 1000));
    send_box(mk_box(0, 0, 0, 0, 0, 0), 0);
    send_box(mk_box(1000, 0, 0, 0, 0, 0), 0);
    send_box(mk_box(1001, 0, 0, 0, 0, 0), 0);
    send_box(mk_box(1005, 0, 0, 5, 0, 0), 0);
    send_box(mk_box(1006, 0, 0, 5, 0, 0), 2);
    send_box(mk_box(0, -1001, 0, 0, 0, 0), 0);
    send_box(mk_box(0, 0, 1001, 0, 0, 0), 0);
    send_box(mk_box(0, 0, -1001, 0, 0, 0), 0);
    send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767), 0);
    send_box(mk_box(-32768, 0, 0, 0, 0, 0), 0);
    drain();

    p8000 = pack_plane(-32768, -32768, -32768, -32768);
    load_planes(p8000, p8000, p8000, p8000, p8000, p8000);
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767), 0);
    send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767), 0);
    drain();

    p7fff = pack_plane(32767, 32767, 32767, 32767);
    load_planes(p7fff, p7fff, p7fff, p7fff, p7fff, p7fff);
    send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767), 0);
    send_box(mk_box(-32768, -32768, -32768, 0, 0, 0), 0);
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767), 0);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      kind = phase % 3;
      quiet = ($urandom_range(0, 3) == 0);
      if (kind == 1) begin
        load_planes(random_plane(), random_plane(), random_plane(),
                    random_plane(), random_plane(), random_plane());
      end else if (kind == 2) begin
        load_planes({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      end else begin
        load_planes(cube_face(0, 1), cube_face(0, -1), cube_face(1, 1),
                    cube_face(1, -1), cube_face(2, 1), cube_face(2, -1));
      end
      for (int n = 0; n < 100; n++) begin
        send_box(random_box(), next_gap(quiet));
        if ($urandom_range(0, 79) == 0) begin
          drain();
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/afv_pkg.sv
sv/afv_in_if.sv
sv/afv_out_if.sv
sv/afv_cfg_if.sv
sv/aabb_frustum_visibility_test.sv
bench/visibility_checker.sv
bench/testbench.sv
